FILE: design/sfr_pkg.sv
// Package for the stuffed frame receiver: line codes, result kinds, parser
// states and the result record shared by the parser, output stage and top.
// No dependencies.
`default_nettype none

package sfr_pkg;

  // Field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LIMIT_W = 11;
  localparam int unsigned LEN_W   = 10;
  localparam int unsigned KIND_W  = 3;

  // Default storage limit and the reset value of the frame limit register
  localparam int unsigned           MAX_FRAME_BYTES_DEF = 1024;
  localparam logic [LIMIT_W-1:0]    FRAME_LIMIT_RST     = 11'd1024;

  // Line codes
  localparam logic [BYTE_W-1:0] FLAG_BYTE = 8'h7E;
  localparam logic [BYTE_W-1:0] ADDR_CMD  = 8'h03;
  localparam logic [BYTE_W-1:0] ESC_BYTE  = 8'h7D;
  localparam logic [BYTE_W-1:0] ESC_MASK  = 8'h20;
  localparam logic [BYTE_W-1:0] CTRL_SEQ0 = 8'h00;
  localparam logic [BYTE_W-1:0] CTRL_SEQ1 = 8'h40;
  localparam logic [BYTE_W-1:0] CTRL_DISC = 8'h0B;

  // Reply control bytes
  localparam logic [BYTE_W-1:0] RR_SEQ0  = 8'h05;
  localparam logic [BYTE_W-1:0] RR_SEQ1  = 8'h85;
  localparam logic [BYTE_W-1:0] REJ_SEQ0 = 8'h01;
  localparam logic [BYTE_W-1:0] REJ_SEQ1 = 8'h81;

  // Result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_PAYLOAD = 3'd0,
    KIND_ACCEPT  = 3'd1,
    KIND_REJECT  = 3'd2,
    KIND_TOOLONG = 3'd3,
    KIND_DISC    = 3'd4
  } kind_t;

  // Parser states, one-hot
  typedef enum logic [5:0] {
    ST_HUNT = 6'b000001,
    ST_FLAG = 6'b000010,
    ST_ADDR = 6'b000100,
    ST_CTRL = 6'b001000,
    ST_DATA = 6'b010000,
    ST_ESC  = 6'b100000
  } parse_state_t;

  // One result item plus its valid flag
  typedef struct packed {
    logic              vld;
    kind_t             kind;
    logic [BYTE_W-1:0] payload;
    logic [LEN_W-1:0]  len;
    logic [BYTE_W-1:0] ctl;
  } result_t;

endpackage

`default_nettype wire

FILE: design/sfr_parser.sv
// Frame parser: holds the frame state and works out, for one line byte, the
// next state and the result item it causes. Depends on sfr_pkg.
`default_nettype none

module sfr_parser #(
  parameter int unsigned MAX_FRAME_BYTES = sfr_pkg::MAX_FRAME_BYTES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         step,
  input  wire logic [sfr_pkg::BYTE_W-1:0]   line_byte,
  input  wire logic [sfr_pkg::LIMIT_W-1:0]  frame_limit,
  output sfr_pkg::result_t                  res
);

  localparam int unsigned CNT_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned CMP_W = (CNT_W > sfr_pkg::LIMIT_W) ? CNT_W : sfr_pkg::LIMIT_W;

  sfr_pkg::parse_state_t state_r, state_nxt;
  logic                       seq_bit_r, seq_bit_nxt;
  logic                       exp_seq_r, exp_seq_nxt;
  logic [sfr_pkg::BYTE_W-1:0] held_r, held_nxt;
  logic [sfr_pkg::BYTE_W-1:0] xor_r, xor_nxt;
  logic [CNT_W-1:0]           count_r, count_nxt;

  logic                       do_store;
  logic [sfr_pkg::BYTE_W-1:0] store_val;
  logic [CMP_W-1:0]           lim_cfg;
  logic [CMP_W-1:0]           lim_max;
  logic [CMP_W-1:0]           lim_eff;
  logic                       over_limit;

  // Effective limit: smaller of the register and the storage bound
  assign lim_cfg    = CMP_W'(frame_limit);
  assign lim_max    = CMP_W'(MAX_FRAME_BYTES);
  assign lim_eff    = (lim_cfg > lim_max) ? lim_max : lim_cfg;
  assign over_limit = (CMP_W'(count_r) >= lim_eff);

  // Next state and result for one byte
  always_comb begin
    state_nxt   = state_r;
    seq_bit_nxt = seq_bit_r;
    exp_seq_nxt = exp_seq_r;
    held_nxt    = held_r;
    xor_nxt     = xor_r;
    count_nxt   = count_r;
    res         = '0;
    do_store    = 1'b0;
    store_val   = line_byte;

    if (step) begin
      unique case (state_r)
        sfr_pkg::ST_HUNT: begin
          if (line_byte == sfr_pkg::FLAG_BYTE) state_nxt = sfr_pkg::ST_FLAG;
        end
        sfr_pkg::ST_FLAG: begin
          // repeated flags keep waiting for the address
          if (line_byte == sfr_pkg::ADDR_CMD) begin
            state_nxt = sfr_pkg::ST_ADDR;
          end else if (line_byte != sfr_pkg::FLAG_BYTE) begin
            state_nxt = sfr_pkg::ST_HUNT;
          end
        end
        sfr_pkg::ST_ADDR: begin
          if (line_byte == sfr_pkg::CTRL_SEQ0 || line_byte == sfr_pkg::CTRL_SEQ1) begin
            seq_bit_nxt = line_byte[6];
            state_nxt   = sfr_pkg::ST_CTRL;
          end else begin
            state_nxt = sfr_pkg::ST_HUNT;
            if (line_byte == sfr_pkg::CTRL_DISC) begin
              res.vld  = 1'b1;
              res.kind = sfr_pkg::KIND_DISC;
            end
          end
        end
        sfr_pkg::ST_CTRL: begin
          // header check is address XOR control
          if (line_byte == (sfr_pkg::ADDR_CMD ^
                            (seq_bit_r ? sfr_pkg::CTRL_SEQ1 : sfr_pkg::CTRL_SEQ0))) begin
            state_nxt = sfr_pkg::ST_DATA;
            count_nxt = '0;
            xor_nxt   = '0;
          end else begin
            state_nxt = sfr_pkg::ST_HUNT;
          end
        end
        sfr_pkg::ST_DATA: begin
          if (line_byte == sfr_pkg::ESC_BYTE) begin
            state_nxt = sfr_pkg::ST_ESC;
          end else if (line_byte == sfr_pkg::FLAG_BYTE) begin
            // closing flag: held byte is BCC2
            state_nxt = sfr_pkg::ST_HUNT;
            count_nxt = '0;
            if (count_r != '0) begin
              res.vld = 1'b1;
              if (xor_r == held_r) begin
                exp_seq_nxt = ~seq_bit_r;
                res.kind    = sfr_pkg::KIND_ACCEPT;
                res.len     = sfr_pkg::LEN_W'(CNT_W'(count_r - CNT_W'(1)));
                res.ctl     = seq_bit_r ? sfr_pkg::RR_SEQ0 : sfr_pkg::RR_SEQ1;
              end else begin
                res.kind = sfr_pkg::KIND_REJECT;
                res.ctl  = exp_seq_r ? sfr_pkg::REJ_SEQ1 : sfr_pkg::REJ_SEQ0;
              end
            end
          end else begin
            do_store = 1'b1;
          end
        end
        sfr_pkg::ST_ESC: begin
          do_store  = 1'b1;
          store_val = line_byte ^ sfr_pkg::ESC_MASK;
        end
        default: begin
          state_nxt = sfr_pkg::ST_HUNT;
        end
      endcase

      // Store one destuffed byte, releasing the one held before it, or end the frame as too long
      if (do_store) begin
        if (over_limit) begin
          state_nxt = sfr_pkg::ST_HUNT;
          count_nxt = '0;
          res.vld   = 1'b1;
          res.kind  = sfr_pkg::KIND_TOOLONG;
        end else begin
          state_nxt = sfr_pkg::ST_DATA;
          count_nxt = count_r + CNT_W'(1);
          held_nxt  = store_val;
          if (count_r != '0) begin
            xor_nxt     = xor_r ^ held_r;
            res.vld     = 1'b1;
            res.kind    = sfr_pkg::KIND_PAYLOAD;
            res.payload = held_r;
          end
        end
      end
    end
  end

  // Frame state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= sfr_pkg::ST_HUNT;
      seq_bit_r <= 1'b0;
      exp_seq_r <= 1'b0;
      held_r    <= '0;
      xor_r     <= '0;
      count_r   <= '0;
    end else begin
      state_r   <= state_nxt;
      seq_bit_r <= seq_bit_nxt;
      exp_seq_r <= exp_seq_nxt;
      held_r    <= held_nxt;
      xor_r     <= xor_nxt;
      count_r   <= count_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: design/sfr_out_stage.sv
// Result register: captures a result item from the parser and holds it
// until the receiver takes it. Depends on sfr_pkg.
`default_nettype none

module sfr_out_stage (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             load,
  input  wire sfr_pkg::result_t res,
  input  wire logic             out_ready,
  output logic                  out_valid,
  output logic                  free,
  output sfr_pkg::result_t      held
);

  logic             valid_r, valid_nxt;
  sfr_pkg::result_t data_r;

  // Room for a new item when empty or being taken this cycle
  assign free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load && res.vld) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (load && res.vld) begin
      data_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign held      = data_r;

endmodule

`default_nettype wire

FILE: design/stuffed_frame_receiver_core.sv
// Byte-stuffed stop-and-wait frame receiver, top level.
// Depends on sfr_pkg, sfr_parser and sfr_out_stage.
//
// Usage:
//   Input channel in_valid/in_ready carries one raw line byte per item.
//   Result channel out_valid/out_ready carries zero or one result per input
//   item: a destuffed payload byte (sent one byte late, so BCC2 never leaves),
//   or a verdict at the closing flag (accepted with length and RR control,
//   rejected with REJ control), too long, or disconnect.
//   cfg_wr_en/cfg_wr_data write the frame limit; write it
//   only while no item is in flight.
// Timing:
//   An accepted byte is held in the input register and is parsed as it
//   moves to the result register; out_valid rises when that register
//   loads. One item per cycle is sustained while out_ready stays high;
//   the parser state update is the feedback loop that sets this.
// Reset (rst_n low, synchronous): parser hunts for the opening flag, both
//   sequence bits clear, frame limit 1024, both registers empty.
// Stall: when out_ready is low with a result waiting, the input register
//   holds one more byte and in_ready then drops until the result is taken.
`default_nettype none

module stuffed_frame_receiver_core #(
  parameter int unsigned MAX_FRAME_BYTES = sfr_pkg::MAX_FRAME_BYTES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [sfr_pkg::BYTE_W-1:0]   in_line_byte,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [sfr_pkg::KIND_W-1:0]        out_kind,
  output logic [sfr_pkg::BYTE_W-1:0]        out_payload_byte,
  output logic [sfr_pkg::LEN_W-1:0]         out_packet_length,
  output logic [sfr_pkg::BYTE_W-1:0]        out_reply_control,
  input  wire logic                         cfg_wr_en,
  input  wire logic [sfr_pkg::LIMIT_W-1:0]  cfg_wr_data
);

  logic                        in_vld_r, in_vld_nxt;
  logic [sfr_pkg::BYTE_W-1:0]  in_byte_r;
  logic [sfr_pkg::LIMIT_W-1:0] limit_r;
  logic                        out_free;
  logic                        advance;
  sfr_pkg::result_t            res;
  sfr_pkg::result_t            held;

  // Item moves from input register into the parser and result register
  assign advance  = in_vld_r && out_free;
  assign in_ready = !in_vld_r || advance;

  // Input register
  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_valid && in_ready) begin
      in_vld_nxt = 1'b1;
    end else if (advance) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_line_byte;
    end
  end

  // Frame limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= sfr_pkg::FRAME_LIMIT_RST;
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

  sfr_parser #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (advance),
    .line_byte   (in_byte_r),
    .frame_limit (limit_r),
    .res         (res)
  );

  sfr_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .res       (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .free      (out_free),
    .held      (held)
  );

  assign out_kind          = held.kind;
  assign out_payload_byte  = held.payload;
  assign out_packet_length = held.len;
  assign out_reply_control = held.ctl;

`ifndef SYNTHESIS
  // Full input register behind a stalled result must block new items
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && out_valid && !out_ready) |-> !in_ready)
    else $error("item taken while both stages are full");

  // A payload item carries no length and no reply control
  a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == sfr_pkg::KIND_PAYLOAD) |->
      (out_packet_length == '0 && out_reply_control == '0))
    else $error("payload item with verdict fields set");

  // An accepted frame answers with RR
  a_accept_rr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == sfr_pkg::KIND_ACCEPT) |->
      (out_reply_control == sfr_pkg::RR_SEQ0 || out_reply_control == sfr_pkg::RR_SEQ1))
    else $error("accept without RR control");

  // A rejected frame answers with REJ and no length
  a_reject_rej: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == sfr_pkg::KIND_REJECT) |->
      (out_packet_length == '0 && (out_reply_control == sfr_pkg::REJ_SEQ0 ||
                                   out_reply_control == sfr_pkg::REJ_SEQ1)))
    else $error("reject without REJ control");
`endif

endmodule

`default_nettype wire

FILE: test/stuffed_frame_receiver_core_test.sv
// Self-checking testbench for stuffed_frame_receiver_core: directed and random HDLC-style frames,
// checked item by item against an in-bench frame parser model with random idling on both sides.
// Depends on sfr_pkg and the stuffed_frame_receiver_core RTL.
`timescale 1ns / 1ps

module stuffed_frame_receiver_core_test;

  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int TIMEOUT_NS    = 5_000_000;

  typedef logic [sfr_pkg::BYTE_W-1:0] line_q_t[$];

  typedef struct packed {
    sfr_pkg::kind_t             kind;
    logic [sfr_pkg::BYTE_W-1:0] payload;
    logic [sfr_pkg::LEN_W-1:0]  len;
    logic [sfr_pkg::BYTE_W-1:0] ctl;
  } rx_result_t;

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  logic [sfr_pkg::BYTE_W-1:0]  in_line_byte;
  logic                        out_valid;
  logic                        out_ready;
  logic [sfr_pkg::KIND_W-1:0]  out_kind;
  logic [sfr_pkg::BYTE_W-1:0]  out_payload_byte;
  logic [sfr_pkg::LEN_W-1:0]   out_packet_length;
  logic [sfr_pkg::BYTE_W-1:0]  out_reply_control;
  logic                        cfg_wr_en;
  logic [sfr_pkg::LIMIT_W-1:0] cfg_wr_data;

  // Frame parser model state
  sfr_pkg::parse_state_t       rx_state        = sfr_pkg::ST_HUNT;
  logic                        rx_seq_bit      = 1'b0;
  logic                        rx_expected_seq = 1'b0;
  logic [sfr_pkg::BYTE_W-1:0]  rx_held         = '0;
  logic [sfr_pkg::BYTE_W-1:0]  rx_xor          = '0;
  int unsigned                 rx_count        = 0;
  logic [sfr_pkg::LIMIT_W-1:0] rx_limit        = sfr_pkg::FRAME_LIMIT_RST;

  rx_result_t          results_due[$];
  int                  mismatch_count  = 0;
  int                  frame_bytes_sent = 0;
  int                  burst_left      = 0;
  bit                  hold_off_req    = 1'b0;

  stuffed_frame_receiver_core DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_line_byte      (in_line_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_payload_byte  (out_payload_byte),
    .out_packet_length (out_packet_length),
    .out_reply_control (out_reply_control),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Store one destuffed data byte; the byte held from last time goes out
  function automatic void store_data_byte(input logic [sfr_pkg::BYTE_W-1:0] b,
                                          output bit has_res, output rx_result_t res);
    int unsigned lim;
    lim = rx_limit;
    if (lim > sfr_pkg::MAX_FRAME_BYTES_DEF) lim = sfr_pkg::MAX_FRAME_BYTES_DEF;
    has_res = 1'b0;
    res = '0;
    rx_state = sfr_pkg::ST_DATA;
    if (rx_count >= lim) begin
      rx_state = sfr_pkg::ST_HUNT;
      rx_count = 0;
      has_res = 1'b1;
      res.kind = sfr_pkg::KIND_TOOLONG;
    end else begin
      rx_count++;
      if (rx_count >= 2) begin
        rx_xor ^= rx_held;
        has_res = 1'b1;
        res.kind = sfr_pkg::KIND_PAYLOAD;
        res.payload = rx_held;
      end
      rx_held = b;
    end
  endfunction

  // Advance the parser model by one line byte
  function automatic void decode_line_byte(input logic [sfr_pkg::BYTE_W-1:0] b,
                                           output bit has_res, output rx_result_t res);
    int unsigned n;
    has_res = 1'b0;
    res = '0;
    case (rx_state)
      sfr_pkg::ST_HUNT: begin
        if (b == sfr_pkg::FLAG_BYTE) rx_state = sfr_pkg::ST_FLAG;
      end
      sfr_pkg::ST_FLAG: begin
        if (b == sfr_pkg::ADDR_CMD) rx_state = sfr_pkg::ST_ADDR;
        else if (b != sfr_pkg::FLAG_BYTE) rx_state = sfr_pkg::ST_HUNT;
      end
      sfr_pkg::ST_ADDR: begin
        if (b == sfr_pkg::CTRL_SEQ0 || b == sfr_pkg::CTRL_SEQ1) begin
          rx_seq_bit = b[6];
          rx_state = sfr_pkg::ST_CTRL;
        end else begin
          rx_state = sfr_pkg::ST_HUNT;
          if (b == sfr_pkg::CTRL_DISC) begin
            has_res = 1'b1;
            res.kind = sfr_pkg::KIND_DISC;
          end
        end
      end
      sfr_pkg::ST_CTRL: begin
        if (b == (sfr_pkg::ADDR_CMD ^
                  (rx_seq_bit ? sfr_pkg::CTRL_SEQ1 : sfr_pkg::CTRL_SEQ0))) begin
          rx_state = sfr_pkg::ST_DATA;
          rx_count = 0;
          rx_xor = '0;
        end else begin
          rx_state = sfr_pkg::ST_HUNT;
        end
      end
      sfr_pkg::ST_DATA: begin
        if (b == sfr_pkg::ESC_BYTE) begin
          rx_state = sfr_pkg::ST_ESC;
        end else if (b == sfr_pkg::FLAG_BYTE) begin
          n = rx_count;
          rx_state = sfr_pkg::ST_HUNT;
          rx_count = 0;
          // closing flag with nothing stored gives no verdict
          if (n >= 1) begin
            has_res = 1'b1;
            if (rx_xor == rx_held) begin
              rx_expected_seq = ~rx_seq_bit;
              res.kind = sfr_pkg::KIND_ACCEPT;
              res.len = sfr_pkg::LEN_W'(n - 1);
              res.ctl = rx_expected_seq ? sfr_pkg::RR_SEQ1 : sfr_pkg::RR_SEQ0;
            end else begin
              res.kind = sfr_pkg::KIND_REJECT;
              res.ctl = rx_expected_seq ? sfr_pkg::REJ_SEQ1 : sfr_pkg::REJ_SEQ0;
            end
          end
        end else begin
          store_data_byte(b, has_res, res);
        end
      end
      sfr_pkg::ST_ESC: store_data_byte(b ^ sfr_pkg::ESC_MASK, has_res, res);
      default: rx_state = sfr_pkg::ST_HUNT;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Offer one line byte in bursts with random gaps; model it once accepted
  task automatic send_line_byte(input logic [sfr_pkg::BYTE_W-1:0] b);
    bit         has_res;
    rx_result_t res;
    int         gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_line_byte <= b;
    do @(posedge clk); while (!in_ready);
    decode_line_byte(b, has_res, res);
    if (has_res) results_due.push_back(res);
  endtask

  task automatic send_line_bytes(input line_q_t raw);
    foreach (raw[i]) send_line_byte(raw[i]);
  endtask

  // Full frame: header, stuffed body and BCC2, closing flag
  task automatic send_frame(input logic seq, input line_q_t body,
                            input logic [sfr_pkg::BYTE_W-1:0] bcc_flip, input int stuff_pct);
    line_q_t                    raw;
    logic [sfr_pkg::BYTE_W-1:0] ctl;
    logic [sfr_pkg::BYTE_W-1:0] bcc;
    ctl = seq ? sfr_pkg::CTRL_SEQ1 : sfr_pkg::CTRL_SEQ0;
    bcc = bcc_flip;
    foreach (body[i]) bcc ^= body[i];
    body.push_back(bcc);
    raw.push_back(sfr_pkg::FLAG_BYTE);
    raw.push_back(sfr_pkg::ADDR_CMD);
    raw.push_back(ctl);
    raw.push_back(sfr_pkg::ADDR_CMD ^ ctl);
    foreach (body[i]) begin
      // flag and escape must be escaped; any other byte may be
      if (body[i] == sfr_pkg::FLAG_BYTE || body[i] == sfr_pkg::ESC_BYTE ||
          $urandom_range(0, 99) < stuff_pct) begin
        raw.push_back(sfr_pkg::ESC_BYTE);
        raw.push_back(body[i] ^ sfr_pkg::ESC_MASK);
      end else begin
        raw.push_back(body[i]);
      end
    end
    raw.push_back(sfr_pkg::FLAG_BYTE);
    frame_bytes_sent += raw.size();
    send_line_bytes(raw);
  endtask

  // Random body, biased towards bytes that need escaping
  function automatic line_q_t rand_body(input int len);
    line_q_t q;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 7))
        0: q.push_back(sfr_pkg::FLAG_BYTE);
        1: q.push_back(sfr_pkg::ESC_BYTE);
        default: q.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    return q;
  endfunction

  // Stop offering, let every expected item out, then let the pipeline empty
  task automatic settle_block();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_frame_limit(input logic [sfr_pkg::LIMIT_W-1:0] v);
    settle_block();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    rx_limit = v;
  endtask

  task automatic test_basic_frames();
    line_q_t body;
    write_frame_limit(11'd1024);
    body = {8'h00, 8'hFF, sfr_pkg::FLAG_BYTE, sfr_pkg::ESC_BYTE, 8'h55};
    send_frame(1'b0, body, 8'h00, 0);
    body = {8'hA5};
    send_frame(1'b1, body, 8'h00, 100);
  endtask

  task automatic test_header_faults();
    line_q_t raw;
    // bad address, bad control, bad header check, stray disconnect code,
    // then repeated flags leading into a real disconnect
    raw = {sfr_pkg::FLAG_BYTE, 8'h02, sfr_pkg::FLAG_BYTE, sfr_pkg::ADDR_CMD, 8'h01,
           sfr_pkg::FLAG_BYTE, sfr_pkg::ADDR_CMD, sfr_pkg::CTRL_SEQ0, 8'h43,
           sfr_pkg::CTRL_DISC, sfr_pkg::FLAG_BYTE, sfr_pkg::FLAG_BYTE, sfr_pkg::FLAG_BYTE,
           sfr_pkg::ADDR_CMD, sfr_pkg::CTRL_DISC};
    send_line_bytes(raw);
  endtask

  task automatic test_bcc_errors();
    line_q_t body;
    body = {8'h12, 8'h34};
    send_frame(1'b1, body, 8'h01, 0);
    send_frame(1'b0, body, 8'h00, 0);
    send_frame(1'b0, body, 8'h80, 0);
  endtask

  task automatic test_short_frames();
    line_q_t raw;
    line_q_t body;
    // closing flag straight after the header
    raw = {sfr_pkg::FLAG_BYTE, sfr_pkg::ADDR_CMD, sfr_pkg::CTRL_SEQ1,
           sfr_pkg::ADDR_CMD ^ sfr_pkg::CTRL_SEQ1, sfr_pkg::FLAG_BYTE};
    send_line_bytes(raw);
    // BCC2 only
    send_frame(1'b1, body, 8'h00, 0);
    // escaped flag is data, not a frame end
    raw = {sfr_pkg::FLAG_BYTE, sfr_pkg::ADDR_CMD, sfr_pkg::CTRL_SEQ0, sfr_pkg::ADDR_CMD,
           sfr_pkg::ESC_BYTE, sfr_pkg::FLAG_BYTE, 8'h5E, sfr_pkg::FLAG_BYTE};
    send_line_bytes(raw);
  endtask

  task automatic test_frame_limits();
    line_q_t body;
    write_frame_limit(11'd1);
    send_frame(1'b0, body, 8'h00, 0);
    body = {8'h11};
    send_frame(1'b1, body, 8'h00, 0);
    // escaped BCC2 past the limit
    body = {sfr_pkg::FLAG_BYTE};
    send_frame(1'b0, body, 8'h00, 0);
    write_frame_limit(11'd0);
    body.delete();
    send_frame(1'b1, body, 8'h00, 0);
    // register above the storage size
    write_frame_limit(11'd2047);
    send_frame(1'b0, rand_body(12), 8'h00, 0);
    write_frame_limit(11'd1024);
    send_frame(1'b1, rand_body(20), 8'h00, 5);
  endtask

  task automatic test_back_pressure();
    hold_off_req = 1'b1;
    send_frame(1'($urandom_range(0, 1)), rand_body(40), 8'h00, 10);
    send_frame(1'($urandom_range(0, 1)), rand_body(8), 8'h00, 10);
    in_valid <= 1'b0;
    while (hold_off_req) @(posedge clk);
  endtask

  task automatic test_random_traffic();
    int          target;
    int unsigned lim;
    int          pick;
    int          len;
    int          k;
    logic        seq;
    line_q_t     raw;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_frame_limit(sfr_pkg::LIMIT_W'($urandom_range(1, 8)));
        1: write_frame_limit(sfr_pkg::LIMIT_W'($urandom_range(9, 40)));
        2: write_frame_limit(11'd1024);
        default: write_frame_limit(11'd2047);
      endcase
      lim = rx_limit;
      if (lim > sfr_pkg::MAX_FRAME_BYTES_DEF) lim = sfr_pkg::MAX_FRAME_BYTES_DEF;
      target = frame_bytes_sent + 140;
      while (frame_bytes_sent < target) begin
        pick = $urandom_range(0, 99);
        seq = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 9) == 0 && lim <= 20) len = $urandom_range(0, lim + 1);
        else len = $urandom_range(0, 12);
        if (pick < 65) begin
          send_frame(seq, rand_body(len), 8'h00, $urandom_range(0, 30));
        end else if (pick < 77) begin
          send_frame(seq, rand_body(len), 8'($urandom_range(1, 255)), $urandom_range(0, 30));
        end else if (pick < 82) begin
          raw = {sfr_pkg::FLAG_BYTE, sfr_pkg::ADDR_CMD, sfr_pkg::CTRL_DISC};
          frame_bytes_sent += raw.size();
          send_line_bytes(raw);
        end else if (pick < 90) begin
          // header with one byte spoilt, then some data and a flag
          raw = {sfr_pkg::FLAG_BYTE, sfr_pkg::ADDR_CMD,
                 seq ? sfr_pkg::CTRL_SEQ1 : sfr_pkg::CTRL_SEQ0,
                 sfr_pkg::ADDR_CMD ^ (seq ? sfr_pkg::CTRL_SEQ1 : sfr_pkg::CTRL_SEQ0)};
          k = $urandom_range(1, 3);
          raw[k] = 8'($urandom_range(0, 255));
          raw = {raw, rand_body($urandom_range(0, 4))};
          raw.push_back(sfr_pkg::FLAG_BYTE);
          frame_bytes_sent += raw.size();
          send_line_bytes(raw);
        end else begin
          send_line_bytes(rand_body($urandom_range(1, 4)));
        end
      end
    end
  endtask

  // Result checker: each accepted item against the oldest expectation
  always @(posedge clk) begin : check_results
    rx_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        report_mismatch("unexpected item kind", out_kind, 0);
      end else begin
        want = results_due.pop_front();
        if (out_kind !== want.kind) report_mismatch("kind", out_kind, want.kind);
        if (out_payload_byte !== want.payload)
          report_mismatch("payload_byte", out_payload_byte, want.payload);
        if (out_packet_length !== want.len)
          report_mismatch("packet_length", out_packet_length, want.len);
        if (out_reply_control !== want.ctl)
          report_mismatch("reply_control", out_reply_control, want.ctl);
      end
    end
  end

  // Receiver: segments of ready, random, toggling or stalled, plus one long hold
  initial begin : receiver_pattern
    int seg_left;
    int mode;
    seg_left = 0;
    mode = 0;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        if (seg_left == 0) begin
          mode = $urandom_range(0, 3);
          seg_left = $urandom_range(1, 40);
        end
        seg_left--;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          2: out_ready <= ~out_ready;
          default: out_ready <= 1'b0;
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_line_byte <= '0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_frames();
    test_header_faults();
    test_bcc_errors();
    test_short_frames();
    test_frame_limits();
    test_back_pressure();
    test_random_traffic();
    settle_block();
    if (mismatch_count == 0 && results_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
